@@ src/rfp_pkg.sv @@
`timescale 1ns / 1ps

package rfp_pkg;

  // frame length limit (payload plus header, length and footer bytes)
  localparam logic [16:0] MaxFrameBytes = 17'd4096;
  localparam logic [16:0] FrameOverhead = 17'd10;

  localparam int unsigned TgtDepth = 9;
  localparam int unsigned TgtIdxW  = $clog2(TgtDepth);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  localparam logic [7:0] HdrByte0 = 8'hF4;
  localparam logic [7:0] HdrByte1 = 8'hF3;
  localparam logic [7:0] HdrByte2 = 8'hF2;
  localparam logic [7:0] HdrByte3 = 8'hF1;
  localparam logic [7:0] FtrByte0 = 8'hF8;
  localparam logic [7:0] FtrByte1 = 8'hF7;
  localparam logic [7:0] FtrByte2 = 8'hF6;
  localparam logic [7:0] FtrByte3 = 8'hF5;
  localparam logic [7:0] HeadMark = 8'hAA;
  localparam logic [7:0] TailMark = 8'h55;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StBadFooter = 2'd1,
    StMalformed = 2'd2,
    StTooLong   = 2'd3
  } rfp_status_e;

  // classified byte as it travels from front to back
  typedef struct packed {
    logic [7:0] data;
    logic [3:0] hdr_hit;
    logic [3:0] ftr_hit;
    logic       is_head;
    logic       is_tail;
  } rfp_tok_t;

  typedef struct packed {
    rfp_status_e status;
    logic        moving;
    logic        still;
    logic        changed;
    logic [7:0]  data_type;
    logic [15:0] moving_distance;
    logic [7:0]  moving_energy;
    logic [15:0] still_distance;
    logic [7:0]  still_energy;
    logic [15:0] detect_distance;
    logic        detail_valid;
  } rfp_res_t;

endpackage

@@ src/radar_frame_parser_unit.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// in        sink       in_valid_i/in_stall_o rx_byte_i
// out       source     out_valid_o/out_stall_i status_o .. detail_valid_o
//
// One byte per cycle while no stall on out holds the flow; a result passes from
// front classification into the two-entry queue, then through the parser FSM into
// the result register. At most one result per byte.
// Reset is asynchronous and puts the parser back into header hunt.
// A stall on out holds the result; the queue absorbs up to two further bytes
// before in_stall_o rises.

module radar_frame_parser_unit import rfp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic        moving_o,
  output logic        still_o,
  output logic        changed_o,
  output logic [7:0]  data_type_o,
  output logic [15:0] moving_distance_o,
  output logic [7:0]  moving_energy_o,
  output logic [15:0] still_distance_o,
  output logic [7:0]  still_energy_o,
  output logic [15:0] detect_distance_o,
  output logic        detail_valid_o
);

  logic     q_full, q_valid, push, pop;
  rfp_tok_t tok_in, tok_out;
  rfp_res_t res;

  rfp_front u_front (
    .in_valid_i (in_valid_i),
    .rx_byte_i  (rx_byte_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .tok_o      (tok_in)
  );

  rfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (tok_in),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .tok_o   (tok_out)
  );

  rfp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .tok_i       (tok_out),
    .pop_o       (pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .res_o       (res)
  );

  assign status_o          = res.status;
  assign moving_o          = res.moving;
  assign still_o           = res.still;
  assign changed_o         = res.changed;
  assign data_type_o       = res.data_type;
  assign moving_distance_o = res.moving_distance;
  assign moving_energy_o   = res.moving_energy;
  assign still_distance_o  = res.still_distance;
  assign still_energy_o    = res.still_energy;
  assign detect_distance_o = res.detect_distance;
  assign detail_valid_o    = res.detail_valid;

endmodule

@@ src/rfp_front.sv @@
`timescale 1ns / 1ps

module rfp_front import rfp_pkg::*; (
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  input  logic       q_full_i,
  output logic       in_stall_o,
  output logic       push_o,
  output rfp_tok_t   tok_o
);

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

  always_comb begin
    tok_o.data       = rx_byte_i;
    tok_o.hdr_hit[0] = (rx_byte_i == HdrByte0);
    tok_o.hdr_hit[1] = (rx_byte_i == HdrByte1);
    tok_o.hdr_hit[2] = (rx_byte_i == HdrByte2);
    tok_o.hdr_hit[3] = (rx_byte_i == HdrByte3);
    tok_o.ftr_hit[0] = (rx_byte_i == FtrByte0);
    tok_o.ftr_hit[1] = (rx_byte_i == FtrByte1);
    tok_o.ftr_hit[2] = (rx_byte_i == FtrByte2);
    tok_o.ftr_hit[3] = (rx_byte_i == FtrByte3);
    tok_o.is_head    = (rx_byte_i == HeadMark);
    tok_o.is_tail    = (rx_byte_i == TailMark);
  end

endmodule

@@ src/rfp_queue.sv @@
`timescale 1ns / 1ps

module rfp_queue import rfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  rfp_tok_t tok_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     valid_o,
  output rfp_tok_t tok_o
);

  rfp_tok_t          mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  count_q;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign tok_o   = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

@@ src/rfp_back.sv @@
`timescale 1ns / 1ps

module rfp_back import rfp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  input  rfp_tok_t tok_i,
  output logic     pop_o,
  input  logic     out_stall_i,
  output logic     out_valid_o,
  output rfp_res_t res_o
);

  typedef enum logic [2:0] {
    PhHunt    = 3'd0,
    PhLenLo   = 3'd1,
    PhLenHi   = 3'd2,
    PhPayload = 3'd3,
    PhFooter  = 3'd4
  } phase_e;

  phase_e       phase_q, phase_d;
  logic [1:0]   mc_q, mc_d;
  logic [15:0]  len_q, len_d;
  logic [15:0]  idx_q, idx_d;
  logic [7:0]   type_q, type_d;
  logic         mark_q, mark_d;
  logic [15:0]  tail_q, tail_d;
  logic         last_mv_q, last_mv_d;
  logic         last_st_q, last_st_d;
  logic [7:0]   tgt_q [TgtDepth];
  logic         tgt_we;
  logic [TgtIdxW-1:0] tgt_idx;
  logic         out_valid_q;
  rfp_res_t     res_q, res_d;
  logic         res_fire;
  logic [16:0]  idx_nx;
  logic [16:0]  len_sum;

  assign pop_o       = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  assign idx_nx  = {1'b0, idx_q} + 17'd1;
  assign len_sum = {1'b0, tok_i.data, len_q[7:0]} + FrameOverhead;
  assign tgt_idx = TgtIdxW'(idx_q - 16'd2);

  always_comb begin
    phase_d   = phase_q;
    mc_d      = mc_q;
    len_d     = len_q;
    idx_d     = idx_q;
    type_d    = type_q;
    mark_d    = mark_q;
    tail_d    = tail_q;
    last_mv_d = last_mv_q;
    last_st_d = last_st_q;
    tgt_we    = 1'b0;
    res_fire  = 1'b0;
    res_d     = '0;

    case (phase_q)
      PhLenLo: begin
        len_d   = {8'h00, tok_i.data};
        phase_d = PhLenHi;
      end
      PhLenHi: begin
        len_d = {tok_i.data, len_q[7:0]};
        mc_d  = '0;
        if (len_sum > MaxFrameBytes) begin
          res_fire     = 1'b1;
          res_d.status = StTooLong;
          phase_d      = PhHunt;
        end else begin
          idx_d   = '0;
          type_d  = '0;
          mark_d  = 1'b0;
          tail_d  = '0;
          phase_d = (len_d == '0) ? PhFooter : PhPayload;
        end
      end
      PhPayload: begin
        if (idx_q == 16'd0) begin
          type_d = tok_i.data;
        end else if (idx_q == 16'd1) begin
          mark_d = tok_i.is_head;
        end else if (tail_q == '0 && idx_nx < {1'b0, len_q}) begin
          if (tok_i.is_tail) begin
            tail_d = idx_q;
          end else if (idx_q < 16'(TgtDepth + 2)) begin
            tgt_we = 1'b1;
          end
        end
        if (idx_nx >= {1'b0, len_q}) begin
          phase_d = PhFooter;
          mc_d    = '0;
        end else begin
          idx_d = idx_nx[15:0];
        end
      end
      PhFooter: begin
        if (!tok_i.ftr_hit[mc_q]) begin
          res_fire     = 1'b1;
          res_d.status = StBadFooter;
          phase_d      = PhHunt;
          mc_d         = '0;
        end else begin
          mc_d = mc_q + 2'd1;
          if (mc_q == 2'd3) begin
            res_fire = 1'b1;
            phase_d  = PhHunt;
            if (len_q < 16'd5 || !mark_q || tail_q < 16'd3) begin
              res_d.status = StMalformed;
            end else begin
              res_d.status    = StOk;
              res_d.moving    = tgt_q[0][0];
              res_d.still     = tgt_q[0][1];
              res_d.changed   = (tgt_q[0][0] != last_mv_q) || (tgt_q[0][1] != last_st_q);
              res_d.data_type = type_q;
              // full detail needs nine target bytes before the tail marker
              if (tail_q >= 16'(TgtDepth + 2)) begin
                res_d.moving_distance = {tgt_q[2], tgt_q[1]};
                res_d.moving_energy   = tgt_q[3];
                res_d.still_distance  = {tgt_q[5], tgt_q[4]};
                res_d.still_energy    = tgt_q[6];
                res_d.detect_distance = {tgt_q[8], tgt_q[7]};
                res_d.detail_valid    = 1'b1;
              end
              last_mv_d = tgt_q[0][0];
              last_st_d = tgt_q[0][1];
            end
          end
        end
      end
      default: begin
        // header hunt; unused codes land here too
        phase_d = PhHunt;
        if (tok_i.hdr_hit[mc_q]) begin
          mc_d = mc_q + 2'd1;
          if (mc_q == 2'd3) phase_d = PhLenLo;
        end else begin
          mc_d = {1'b0, tok_i.hdr_hit[0]};
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && tgt_we) begin
      tgt_q[tgt_idx] <= tok_i.data;
    end
    if (pop_o && res_fire) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      mc_q        <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      type_q      <= '0;
      mark_q      <= 1'b0;
      tail_q      <= '0;
      last_mv_q   <= 1'b0;
      last_st_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        mc_q        <= mc_d;
        len_q       <= len_d;
        idx_q       <= idx_d;
        type_q      <= type_d;
        mark_q      <= mark_d;
        tail_q      <= tail_d;
        last_mv_q   <= last_mv_d;
        last_st_q   <= last_st_d;
        out_valid_q <= res_fire;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule
